### hdl/fat12_pkg.sv
// shared constants and helpers for the fat12 cluster chain walker
package fat12_pkg;

  localparam int TABLE_BYTES_DEF = 8192;
  localparam int MAX_CHAIN_DEF   = 64;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_WALK = 1'b1;

  localparam logic [15:0] CL_FIRST     = 16'h0002;
  localparam logic [15:0] CL_LAST_DATA = 16'h0FF6;
  localparam logic [11:0] CL_MASK      = 12'hFFF;

  function automatic logic in_chain(input logic [15:0] c);
    in_chain = (c >= CL_FIRST) && (c <= CL_LAST_DATA);
  endfunction

endpackage

### hdl/fat12_cluster_chain_walker.sv
// fat12 cluster chain walker: table memory, step sequencer and result register
// a load request writes one table byte when its address lies inside the table
// a walk request steps, for each chain member, through address add, two byte reads
// through the single registered read port, next-cluster compare and emit, holding in
// emit while the output stalls; an empty chain goes straight to emit and gives one result
// synchronous active-low reset clears the sequencer and output valid; table is not reset
module fat12_cluster_chain_walker #(
  parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF,
  parameter int MAX_CHAIN   = fat12_pkg::MAX_CHAIN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [12:0] in_byte_address,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_first_cluster,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_cluster,
  output logic        out_cluster_valid,
  output logic        out_last,
  output logic        out_truncated
);

  localparam int AW = $clog2(TABLE_BYTES);
  localparam int CW = $clog2(MAX_CHAIN + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_RD0  = 3'd2;
  localparam logic [2:0] ST_RD1  = 3'd3;
  localparam logic [2:0] ST_CALC = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [7:0]    mem [TABLE_BYTES];
  logic [7:0]    rd_data_r;
  logic [7:0]    b0_r;

  logic [2:0]    st_r, st_nxt;
  logic [11:0]   cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [12:0]   addr_r, addr_nxt;
  logic [11:0]   nx_r;
  logic          fin_r, trc_r, vbit_r;

  logic          out_valid_r, out_valid_nxt;
  logic [11:0]   out_cl_r;
  logic          out_cv_r, out_last_r, out_trc_r;

  logic          in_acc;
  logic          out_free;
  logic          emit_go;
  logic [12:0]   op_a, op_b, sum;
  logic [15:0]   word;
  logic [11:0]   nx_c;
  logic          more_c, last_step_c;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = (st_r == ST_EMIT) && out_free;

  // shared adder: cluster plus half cluster, then byte address plus one
  assign op_a = (st_r == ST_ADDR) ? {1'b0, cur_r} : addr_r;
  assign op_b = (st_r == ST_ADDR) ? {2'b00, cur_r[11:1]} : 13'd1;
  assign sum  = op_a + op_b;

  assign word        = {rd_data_r, b0_r};
  assign nx_c        = cur_r[0] ? word[15:4] : (word[11:0] & fat12_pkg::CL_MASK);
  assign more_c      = fat12_pkg::in_chain({4'h0, nx_c});
  assign last_step_c = (cnt_r == CW'(MAX_CHAIN - 1));

  always_ff @(posedge clk) begin
    if (in_acc && (in_func == fat12_pkg::FUNC_LOAD) &&
        ({1'b0, in_byte_address} < 14'(TABLE_BYTES))) begin
      mem[in_byte_address[AW-1:0]] <= in_byte_value;
    end
    rd_data_r <= mem[addr_r[AW-1:0]];
  end

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      ST_IDLE: begin
        if (in_acc && (in_func == fat12_pkg::FUNC_WALK)) begin
          cnt_nxt = '0;
          if (fat12_pkg::in_chain(in_first_cluster)) begin
            cur_nxt = in_first_cluster[11:0];
            st_nxt  = ST_ADDR;
          end else begin
            cur_nxt = '0;
            st_nxt  = ST_EMIT;
          end
        end
      end
      ST_ADDR: begin
        addr_nxt = sum;
        st_nxt   = ST_RD0;
      end
      ST_RD0: begin
        addr_nxt = sum;
        st_nxt   = ST_RD1;
      end
      ST_RD1: st_nxt = ST_CALC;
      ST_CALC: st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (fin_r) begin
            st_nxt = ST_IDLE;
          end else begin
            cur_nxt = nx_r;
            cnt_nxt = cnt_r + CW'(1);
            st_nxt  = ST_ADDR;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cur_r       <= '0;
      cnt_r       <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_RD1) begin
      b0_r <= rd_data_r;
    end
    if ((st_r == ST_IDLE) && in_acc) begin
      vbit_r <= fat12_pkg::in_chain(in_first_cluster);
      fin_r  <= 1'b1;
      trc_r  <= 1'b0;
    end else if (st_r == ST_CALC) begin
      nx_r   <= nx_c;
      fin_r  <= !more_c || last_step_c;
      trc_r  <= more_c && last_step_c;
    end
    if (emit_go) begin
      out_cl_r   <= cur_r;
      out_cv_r   <= vbit_r;
      out_last_r <= fin_r;
      out_trc_r  <= trc_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cluster       = out_cl_r;
  assign out_cluster_valid = out_cv_r;
  assign out_last          = out_last_r;
  assign out_truncated     = out_trc_r;

`ifndef ASSERT_OFF
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == fat12_pkg::FUNC_WALK) |=> (st_r != ST_IDLE))
    else $error("walk request did not start the sequencer");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cluster_valid |-> out_last && !out_truncated)
    else $error("empty chain result not marked last");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last)
    else $error("truncated flag on a non-final result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> (cnt_r < CW'(MAX_CHAIN)))
    else $error("chain count exceeded the limit");
`endif

endmodule

### verif/tb_fat12_cluster_chain_walker.sv
// testbench for the fat12 cluster chain walker: random loads and walks against a predictor
`timescale 1ns / 1ps

module tb_fat12_cluster_chain_walker;

  typedef struct packed {
    logic [11:0] cluster;
    logic        cluster_valid;
    logic        last;
    logic        truncated;
  } chain_link_t;

  class chain_tracker;
    bit [7:0]    fat_bytes [fat12_pkg::TABLE_BYTES_DEF];
    bit          written [fat12_pkg::TABLE_BYTES_DEF];
    logic [11:0] cur_cluster;
    int          emitted;
    chain_link_t expected_links [$];
    int          errors;

    function bit in_range(logic [15:0] c);
      return (c >= fat12_pkg::CL_FIRST) && (c <= fat12_pkg::CL_LAST_DATA);
    endfunction

    function logic [11:0] next_cluster(logic [11:0] c);
      int          off;
      logic [15:0] word;
      off = int'(c) + int'(c >> 1);
      word[7:0]  = (off < fat12_pkg::TABLE_BYTES_DEF) ? fat_bytes[off] : 8'h00;
      word[15:8] = (off + 1 < fat12_pkg::TABLE_BYTES_DEF) ? fat_bytes[off + 1] : 8'h00;
      return c[0] ? word[15:4] : word[11:0];
    endfunction

    // true when a walk from fc reads only loaded table bytes
    function bit chain_is_safe(logic [15:0] fc);
      logic [11:0] c;
      int          off;
      if (!in_range(fc)) return 1'b1;
      c = fc[11:0];
      for (int n = 0; n < fat12_pkg::MAX_CHAIN_DEF; n++) begin
        off = int'(c) + int'(c >> 1);
        if (!written[off] || !written[off + 1]) return 1'b0;
        c = next_cluster(c);
        if (!in_range({4'h0, c})) return 1'b1;
      end
      return 1'b1;
    endfunction

    function void note_request(logic func, logic [12:0] addr, logic [7:0] val,
                               logic [15:0] fc);
      chain_link_t link;
      logic [11:0] c;
      logic [11:0] nx;
      bit          more;
      bit          fin;
      if (func == fat12_pkg::FUNC_LOAD) begin
        if (addr < fat12_pkg::TABLE_BYTES_DEF) begin
          fat_bytes[addr] = val;
          written[addr]   = 1'b1;
        end
        return;
      end
      emitted = 0;
      if (!in_range(fc)) begin
        cur_cluster = 12'h000;
        link.cluster       = 12'h000;
        link.cluster_valid = 1'b0;
        link.last          = 1'b1;
        link.truncated     = 1'b0;
        expected_links.push_back(link);
        return;
      end
      c = fc[11:0];
      for (int n = 0; n < fat12_pkg::MAX_CHAIN_DEF; n++) begin
        nx   = next_cluster(c);
        more = in_range({4'h0, nx});
        fin  = !more || (n == fat12_pkg::MAX_CHAIN_DEF - 1);
        link.cluster       = c;
        link.cluster_valid = 1'b1;
        link.last          = fin;
        link.truncated     = fin && more;
        expected_links.push_back(link);
        emitted++;
        c = nx;
        cur_cluster = c;
        if (fin) break;
      end
    endfunction

    function void check_link(logic [11:0] cl, logic cv, logic lst, logic tr);
      chain_link_t want;
      if (expected_links.size() == 0) begin
        $error("unexpected result: cluster %0h", cl);
        errors++;
        return;
      end
      want = expected_links.pop_front();
      if (cl !== want.cluster) begin
        $error("cluster: expected %0h, actual %0h", want.cluster, cl);
        errors++;
      end
      if (cv !== want.cluster_valid) begin
        $error("cluster_valid: expected %0b, actual %0b", want.cluster_valid, cv);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, lst);
        errors++;
      end
      if (tr !== want.truncated) begin
        $error("truncated: expected %0b, actual %0b", want.truncated, tr);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [12:0] in_byte_address;
  logic [7:0]  in_byte_value;
  logic [15:0] in_first_cluster;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_cluster;
  logic        out_cluster_valid;
  logic        out_last;
  logic        out_truncated;

  chain_tracker tracker = new();
  int sent_items;
  int in_idle_pct;
  int out_stall_pct;
  int hold_left;

  fat12_cluster_chain_walker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_byte_address   (in_byte_address),
    .in_byte_value     (in_byte_value),
    .in_first_cluster  (in_first_cluster),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cluster       (out_cluster),
    .out_cluster_valid (out_cluster_valid),
    .out_last          (out_last),
    .out_truncated     (out_truncated)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_link(out_cluster, out_cluster_valid, out_last, out_truncated);
    end
  end

  task automatic send_request(logic func, logic [12:0] addr, logic [7:0] val,
                              logic [15:0] fc);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_func          <= func;
    in_byte_address  <= addr;
    in_byte_value    <= val;
    in_first_cluster <= fc;
    do @(posedge clk); while (in_stall);
    tracker.note_request(func, addr, val, fc);
    sent_items++;
  endtask

  // rewrite one 12-bit table entry, keeping the neighbor nibble
  task automatic write_fat_entry(logic [11:0] c, logic [11:0] nxt);
    int          off;
    logic [15:0] word;
    off  = int'(c) + int'(c >> 1);
    word = {tracker.fat_bytes[off + 1], tracker.fat_bytes[off]};
    if (c[0]) begin
      word[15:4] = nxt;
    end else begin
      word[11:0] = nxt;
    end
    send_request(fat12_pkg::FUNC_LOAD, 13'(off), word[7:0], 16'($urandom));
    send_request(fat12_pkg::FUNC_LOAD, 13'(off + 1), word[15:8], 16'($urandom));
  endtask

  task automatic issue_walk(logic [15:0] fc);
    if (!tracker.chain_is_safe(fc)) fc = 16'($urandom_range(16'hFF7, 16'hFFFF));
    send_request(fat12_pkg::FUNC_WALK, 13'($urandom), 8'($urandom), fc);
  endtask

  function automatic logic [11:0] pick_chain_end();
    case ($urandom_range(3))
      0: return 12'($urandom_range(12'hFF8, 12'hFFF));
      1: return 12'hFF7;
      2: return 12'($urandom_range(0, 1));
      default: return 12'($urandom_range(12'hFF7, 12'hFFF));
    endcase
  endfunction

  task automatic run_chain();
    int          len;
    logic [11:0] members [$];
    len = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      members.push_back(12'($urandom_range(fat12_pkg::CL_FIRST, fat12_pkg::CL_LAST_DATA)));
    end
    for (int i = 0; i < len - 1; i++) write_fat_entry(members[i], members[i + 1]);
    if ($urandom_range(4) == 0) begin
      write_fat_entry(members[len - 1], members[$urandom_range(0, len - 1)]);
    end else begin
      write_fat_entry(members[len - 1], pick_chain_end());
    end
    issue_walk({4'h0, members[0]});
    if ($urandom_range(3) == 0) issue_walk({4'h0, members[$urandom_range(0, len - 1)]});
  endtask

  // 64 consecutive clusters: ends exactly at the limit, then runs past it
  task automatic run_full_chain();
    logic [11:0] base;
    base = 12'($urandom_range(fat12_pkg::CL_FIRST, fat12_pkg::CL_LAST_DATA - 64));
    for (int i = 0; i < fat12_pkg::MAX_CHAIN_DEF - 1; i++) begin
      write_fat_entry(12'(base + i), 12'(base + i + 1));
    end
    write_fat_entry(12'(base + fat12_pkg::MAX_CHAIN_DEF - 1), 12'hFFF);
    issue_walk({4'h0, base});
    write_fat_entry(12'(base + fat12_pkg::MAX_CHAIN_DEF - 1),
                    12'(base + fat12_pkg::MAX_CHAIN_DEF));
    issue_walk({4'h0, base});
  endtask

  initial begin
    int phase_end;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = fat12_pkg::FUNC_LOAD;
    in_byte_address  = 13'h0000;
    in_byte_value    = 8'h00;
    in_first_cluster = 16'h0000;
    in_idle_pct      = 0;
    out_stall_pct    = 0;
    hold_left        = 0;
    sent_items       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, empty chains, odd and even members, self loop
    send_request(fat12_pkg::FUNC_LOAD, 13'h0000, 8'hFF, 16'hFFFF);
    send_request(fat12_pkg::FUNC_LOAD, 13'h1FFF, 8'h00, 16'h0000);
    issue_walk(16'h0000);
    issue_walk(16'h0001);
    issue_walk(16'h0FF7);
    issue_walk(16'hFFFF);
    issue_walk(16'h1005);
    write_fat_entry(12'h002, 12'hFF6);
    write_fat_entry(12'hFF6, 12'hFFF);
    issue_walk(16'h0002);
    issue_walk(16'h0FF6);
    write_fat_entry(12'h003, 12'h003);
    issue_walk(16'h0003);
    write_fat_entry(12'hFF5, 12'hFF7);
    issue_walk(16'h0FF5);

    // long output hold while requests keep coming
    hold_left = 400;
    issue_walk(16'h0003);
    for (int i = 0; i < 6; i++) send_request(fat12_pkg::FUNC_LOAD, 13'($urandom),
                                             8'($urandom), 16'($urandom));
    issue_walk(16'h0002);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 51; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 51; end
        default: begin in_idle_pct = 8; out_stall_pct = 8; end
      endcase
      phase_end = sent_items + 60;
      if (ph == 2) run_full_chain();
      while (sent_items < phase_end) begin
        case ($urandom_range(19))
          0, 1, 2: begin
            if ($urandom_range(1)) issue_walk(16'($urandom));
            else issue_walk(16'($urandom_range(0, 16'h0FFF)));
          end
          3, 4, 5: send_request(fat12_pkg::FUNC_LOAD, 13'($urandom), 8'($urandom),
                                16'($urandom));
          default: run_chain();
        endcase
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.expected_links.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_links.size() == 0) begin
      $display("PASS fat12_cluster_chain_walker");
    end else begin
      $display("FAIL fat12_cluster_chain_walker");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL fat12_cluster_chain_walker");
    $finish;
  end

endmodule
